// ===== hdl/euler_variable_converter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Euler variable converter assertion macros
// Short forms for the concurrent checks used by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef EULER_VARIABLE_CONVERTER_CORE_ASSERT_SVH
`define EULER_VARIABLE_CONVERTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/evc_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter package
// Widths, codes, shared types and fixed-point helpers of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package evc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int DATA_W    = 32;
	localparam int SAT_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int QBITS     = DATA_W + FRAC_BITS;
	localparam int DIV_LAT   = QBITS + 1;
	localparam int GAMMA_W   = 31;
	localparam int REG_IDX_W = 1;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);

	typedef logic signed [DATA_W-1:0]   word_t;
	typedef logic signed [2*DATA_W-1:0] prod_t;

	localparam prod_t SAT_MAX = (prod_t'(1) <<< (SAT_BITS - 1)) - prod_t'(1);
	localparam prod_t SAT_MIN = -SAT_MAX - prod_t'(1);
	localparam word_t MAX_WORD = word_t'(SAT_MAX);
	localparam word_t MIN_WORD = word_t'(SAT_MIN);
	localparam word_t Q_ONE = word_t'(prod_t'(1) <<< FRAC_BITS);
	localparam logic [QBITS-1:0] QLIM_POS = QBITS'(SAT_MAX);
	localparam logic [QBITS-1:0] QLIM_NEG = QBITS'(SAT_MAX) + QBITS'(1);

	localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(91750);

	localparam logic [1:0] GEO_1D = 2'd0;
	localparam logic [1:0] GEO_2D = 2'd1;

	localparam logic [REG_IDX_W-1:0] REG_GEOMETRY  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ADIABATIC = REG_IDX_W'(1);

	localparam logic OP_CONS_TO_PRIM = 1'b0;
	localparam logic OP_PRIM_TO_CONS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_IMPL = 2'd1,
		ST_ZERO_DIV = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] mode;
		word_t      gm1;
	} cfg_t;

	// One classified cell as it waits in the queue.
	typedef struct packed {
		logic  op;
		logic  two_d;
		logic  ni;
		logic  last;
		word_t n1;
		word_t d1;
		word_t n2;
		word_t d2;
		word_t n3;
		word_t d3;
		word_t vol;
		word_t a;
		word_t b;
		word_t c;
	} item_t;

	typedef struct packed {
		logic  op;
		logic  two_d;
		logic  ni;
		logic  last;
		word_t vol;
		word_t a;
		word_t b;
		word_t c;
	} side_a_t;

	typedef struct packed {
		logic  op;
		logic  ni;
		logic  last;
		logic  zd;
		logic  sat;
		word_t r0;
		word_t r1;
		word_t r2;
		word_t w;
	} side_b_t;

	localparam int SIDE_W = ($bits(side_a_t) > $bits(side_b_t)) ?
		$bits(side_a_t) : $bits(side_b_t);

	typedef struct packed {
		logic neg;
		logic dz;
		logic npos;
		logic nneg;
	} div_ctl_t;

	typedef struct packed {
		word_t v;
		logic  sat;
	} sat_word_t;

	function automatic sat_word_t clamp_word(input prod_t x);
		sat_word_t res;
		res.sat = 1'b0;
		if (x > SAT_MAX) begin
			res.v   = MAX_WORD;
			res.sat = 1'b1;
		end else if (x < SAT_MIN) begin
			res.v   = MIN_WORD;
			res.sat = 1'b1;
		end else begin
			res.v = word_t'(x);
		end
		return res;
	endfunction

	// Rounds a full product on its magnitude; half adds one more bit of shift.
	function automatic sat_word_t mul_round(input prod_t p, input logic half);
		logic [2*DATA_W-1:0] m;
		logic [2*DATA_W-1:0] r;
		prod_t v;
		m = p[2*DATA_W-1] ? $unsigned(-p) : $unsigned(p);
		if (half) begin
			r = (m + ((2*DATA_W)'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
		end else begin
			r = (m + ((2*DATA_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
		v = p[2*DATA_W-1] ? -$signed(r) : $signed(r);
		return clamp_word(v);
	endfunction

	function automatic sat_word_t sat_add(input word_t x, input word_t y, input logic sub);
		prod_t s;
		s = sub ? (prod_t'(x) - prod_t'(y)) : (prod_t'(x) + prod_t'(y));
		return clamp_word(s);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/evc_if.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter channels
// Cell input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface evc_cell_if;
	import evc_pkg::*;
	logic  valid;
	logic  ready;
	logic  operation;
	word_t cell_volume;
	word_t cell_mass;
	word_t cell_momentum_x;
	word_t cell_momentum_y;
	word_t cell_energy;
	word_t cell_density;
	word_t cell_velocity_x;
	word_t cell_velocity_y;
	word_t cell_pressure;
	logic  last_cell;
	modport source (output valid, output operation, output cell_volume, output cell_mass,
		output cell_momentum_x, output cell_momentum_y, output cell_energy,
		output cell_density, output cell_velocity_x, output cell_velocity_y,
		output cell_pressure, output last_cell, input ready);
	modport sink (input valid, input operation, input cell_volume, input cell_mass,
		input cell_momentum_x, input cell_momentum_y, input cell_energy,
		input cell_density, input cell_velocity_x, input cell_velocity_y,
		input cell_pressure, input last_cell, output ready);
endinterface

interface evc_result_if;
	import evc_pkg::*;
	logic    valid;
	logic    ready;
	word_t   out_first;
	word_t   out_second;
	word_t   out_third;
	word_t   out_fourth;
	status_t status_code;
	logic    end_of_sweep;
	modport source (output valid, output out_first, output out_second, output out_third,
		output out_fourth, output status_code, output end_of_sweep, input ready);
	modport sink (input valid, input out_first, input out_second, input out_third,
		input out_fourth, input status_code, input end_of_sweep, output ready);
endinterface

interface evc_cfg_if;
	import evc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [GAMMA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/evc_div.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter divider
// Pipelined restoring divider, one quotient bit per stage, rounded and
// saturated fixed-point quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_div (
	input  logic           clk,
	input  logic           en,
	input  evc_pkg::word_t num,
	input  evc_pkg::word_t den,
	output evc_pkg::word_t quo,
	output logic           zd,
	output logic           sat
);
	import evc_pkg::*;

	logic [DATA_W-1:0] un;
	logic [DATA_W-1:0] ud;
	logic [DATA_W-1:0] ud_s  [0:QBITS];
	logic [DATA_W-1:0] rem_s [0:QBITS];
	logic [QBITS-1:0]  wrd_s [0:QBITS];
	div_ctl_t          ctl_s [0:QBITS];
	logic [QBITS-1:0]  q_fin;
	div_ctl_t          c_fin;

	assign un = num[DATA_W-1] ? $unsigned(-num) : $unsigned(num);
	assign ud = den[DATA_W-1] ? $unsigned(-den) : $unsigned(den);

	// The dividend carries the rounding term so the plain quotient comes out rounded.
	always_ff @(posedge clk) begin
		if (en) begin
			ud_s[0]       <= ud;
			rem_s[0]      <= '0;
			wrd_s[0]      <= QBITS'({un, {FRAC_BITS{1'b0}}}) + QBITS'(ud >> 1);
			ctl_s[0].neg  <= num[DATA_W-1] ^ den[DATA_W-1];
			ctl_s[0].dz   <= (den == '0);
			ctl_s[0].npos <= !num[DATA_W-1] && (num != '0);
			ctl_s[0].nneg <= num[DATA_W-1];
		end
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		logic [DATA_W:0] t;
		logic            ge;
		assign t  = {rem_s[k], wrd_s[k][QBITS-1]};
		assign ge = (t >= {1'b0, ud_s[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DATA_W'(t - {1'b0, ud_s[k]}) : t[DATA_W-1:0];
				wrd_s[k+1] <= {wrd_s[k][QBITS-2:0], ge};
				ud_s[k+1]  <= ud_s[k];
				ctl_s[k+1] <= ctl_s[k];
			end
		end
	end

	assign q_fin = wrd_s[QBITS];
	assign c_fin = ctl_s[QBITS];

	always_comb begin
		zd  = c_fin.dz;
		sat = 1'b0;
		if (c_fin.dz) begin
			if (c_fin.npos) begin
				quo = MAX_WORD;
			end else if (c_fin.nneg) begin
				quo = MIN_WORD;
			end else begin
				quo = '0;
			end
		end else if (!c_fin.neg) begin
			if (q_fin > QLIM_POS) begin
				quo = MAX_WORD;
				sat = 1'b1;
			end else begin
				quo = word_t'(q_fin[DATA_W-1:0]);
			end
		end else begin
			if (q_fin > QLIM_NEG) begin
				quo = MIN_WORD;
				sat = 1'b1;
			end else begin
				quo = -word_t'(q_fin[DATA_W-1:0]);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/evc_delay.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter delay line
// Carries item data and valid alongside a divider, stage for stage.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_delay (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  logic [evc_pkg::SIDE_W-1:0] dat_in,
	output logic                       vld_out,
	output logic [evc_pkg::SIDE_W-1:0] dat_out
);
	import evc_pkg::*;

	logic              vld_s [DIV_LAT];
	logic [SIDE_W-1:0] dat_s [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s[0] <= dat_in;
			for (int i = 1; i < DIV_LAT; i++) begin
				dat_s[i] <= dat_s[i-1];
			end
		end
	end

	assign vld_out = vld_s[DIV_LAT-1];
	assign dat_out = dat_s[DIV_LAT-1];

endmodule

`default_nettype wire

// ===== hdl/evc_front.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter front end
// Accepts cells, picks divider operands for the operation and mode, and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_front (
	input  logic           clk,
	input  logic           arst_n,
	evc_cell_if.sink       cells,
	input  evc_pkg::cfg_t  cfg,
	input  logic           pop,
	output logic           item_vld,
	output evc_pkg::item_t item
);
	import evc_pkg::*;

	item_t               cls;
	item_t               buf_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     cnt_q;
	logic                push;

	assign cells.ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign push        = cells.valid && cells.ready;
	assign item_vld    = (cnt_q != '0);
	assign item        = buf_q[rd_q];

	always_comb begin
		cls       = '0;
		cls.op    = cells.operation;
		cls.two_d = (cfg.mode == GEO_2D);
		cls.ni    = cfg.mode[1];
		cls.last  = cells.last_cell;
		cls.vol   = cells.cell_volume;
		if (cells.operation == OP_CONS_TO_PRIM) begin
			cls.n1 = cells.cell_mass;
			cls.d1 = cells.cell_volume;
			cls.n2 = cells.cell_momentum_x;
			cls.d2 = cells.cell_mass;
			cls.n3 = cls.two_d ? cells.cell_momentum_y : '0;
			cls.d3 = cells.cell_mass;
			cls.a  = cells.cell_mass;
			cls.b  = cells.cell_energy;
		end else begin
			// Only the first divider is used; the others get a harmless divisor.
			cls.n1 = cells.cell_pressure;
			cls.d1 = cfg.gm1;
			cls.d2 = MAX_WORD;
			cls.d3 = MAX_WORD;
			cls.a  = cells.cell_density;
			cls.b  = cells.cell_velocity_x;
			cls.c  = cls.two_d ? cells.cell_velocity_y : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/evc_back.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter back end
// Divider bank, three multiply levels, final divider and result register,
// all advancing together while the result register can move.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  evc_pkg::cfg_t  cfg,
	input  logic           item_vld,
	input  evc_pkg::item_t item,
	output logic           pop,
	evc_result_if.source   results
);
	import evc_pkg::*;

	typedef struct packed {
		logic  op;
		logic  ni;
		logic  last;
		logic  zd;
		logic  sat;
		word_t vol;
		word_t a;
		word_t b;
		word_t c;
		word_t r0;
		word_t r1;
		word_t r2;
		word_t pint;
	} stage_t;

	logic        en;
	word_t       q1, q2, q3, q4;
	logic        zd1, zd2, zd3, zd4;
	logic        sat1, sat2, sat3, sat4;
	side_a_t     sa_in, sa_out;
	side_b_t     sb_in, sb_out;
	logic [SIDE_W-1:0] dat_a, dat_b;
	logic        vld_a, vld_b;

	stage_t      st_a, st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8, st_s9;
	stage_t      nx_s3, nx_s4, nx_s6, nx_s7, nx_s9;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	prod_t       p_x_s2, p_y_s2, p_z_s2;
	word_t       x_s3, y_s3;
	word_t       ksum_s4;
	prod_t       p_k_s5, p_u_s5, p_v_s5;
	word_t       ke_s6;
	word_t       sum_s7;
	prod_t       p_w_s8;
	word_t       w_s9;

	sat_word_t   rx, ry, rz, ks, rk, ru, rv, sm, rw;
	word_t       mx_a, mx_b;
	logic        fin_zd, fin_sat;
	word_t       fin_r3;

	logic        ovld_q;
	word_t       first_q, second_q, third_q, fourth_q;
	status_t     status_q;
	logic        last_q;

	assign en  = !ovld_q || results.ready;
	assign pop = en && item_vld;

	evc_div u_div_a1 (.clk(clk), .en(en), .num(item.n1), .den(item.d1),
		.quo(q1), .zd(zd1), .sat(sat1));
	evc_div u_div_a2 (.clk(clk), .en(en), .num(item.n2), .den(item.d2),
		.quo(q2), .zd(zd2), .sat(sat2));
	evc_div u_div_a3 (.clk(clk), .en(en), .num(item.n3), .den(item.d3),
		.quo(q3), .zd(zd3), .sat(sat3));

	always_comb begin
		sa_in.op    = item.op;
		sa_in.two_d = item.two_d;
		sa_in.ni    = item.ni;
		sa_in.last  = item.last;
		sa_in.vol   = item.vol;
		sa_in.a     = item.a;
		sa_in.b     = item.b;
		sa_in.c     = item.c;
	end

	evc_delay u_dly_a (.clk(clk), .arst_n(arst_n), .en(en), .vld_in(item_vld),
		.dat_in(SIDE_W'(sa_in)), .vld_out(vld_a), .dat_out(dat_a));

	assign sa_out = side_a_t'(dat_a[$bits(side_a_t)-1:0]);

	// Quotients of the first divider bank become density and velocities, or p/(gamma-1).
	always_comb begin
		st_a      = '0;
		st_a.op   = sa_out.op;
		st_a.ni   = sa_out.ni;
		st_a.last = sa_out.last;
		st_a.vol  = sa_out.vol;
		st_a.a    = sa_out.a;
		st_a.b    = sa_out.b;
		st_a.c    = sa_out.c;
		if (sa_out.op == OP_CONS_TO_PRIM) begin
			st_a.r0  = q1;
			st_a.r1  = q2;
			st_a.r2  = sa_out.two_d ? q3 : '0;
			st_a.zd  = zd1 || zd2 || (sa_out.two_d && zd3);
			st_a.sat = sat1 || sat2 || (sa_out.two_d && sat3);
		end else begin
			st_a.pint = q1;
			st_a.zd   = zd1;
			st_a.sat  = sat1;
		end
	end

	assign mx_a = (st_s1.op == OP_PRIM_TO_CONS) ? st_s1.b : st_s1.r1;
	assign mx_b = (st_s1.op == OP_PRIM_TO_CONS) ? st_s1.c : st_s1.r2;

	assign rx = mul_round(p_x_s2, 1'b0);
	assign ry = mul_round(p_y_s2, 1'b0);
	assign rz = mul_round(p_z_s2, 1'b0);
	assign ks = sat_add(x_s3, y_s3, 1'b0);
	assign rk = mul_round(p_k_s5, 1'b1);
	assign ru = mul_round(p_u_s5, 1'b0);
	assign rv = mul_round(p_v_s5, 1'b0);
	assign sm = (st_s6.op == OP_CONS_TO_PRIM) ? sat_add(st_s6.b, ke_s6, 1'b1) :
		sat_add(ke_s6, st_s6.pint, 1'b0);
	assign rw = mul_round(p_w_s8, 1'b0);

	// Stage contents after each rounding step, with the saturation flags folded in.
	always_comb begin
		nx_s3     = st_s2;
		nx_s3.sat = st_s2.sat || rx.sat || ry.sat ||
			((st_s2.op == OP_PRIM_TO_CONS) && rz.sat);
		if (st_s2.op == OP_PRIM_TO_CONS) begin
			nx_s3.r0 = rz.v;
		end

		nx_s4     = st_s3;
		nx_s4.sat = st_s3.sat || ks.sat;

		nx_s6     = st_s5;
		nx_s6.sat = st_s5.sat || rk.sat ||
			((st_s5.op == OP_PRIM_TO_CONS) && (ru.sat || rv.sat));
		if (st_s5.op == OP_PRIM_TO_CONS) begin
			nx_s6.r1 = ru.v;
			nx_s6.r2 = rv.v;
		end

		nx_s7     = st_s6;
		nx_s7.sat = st_s6.sat || sm.sat;

		nx_s9     = st_s8;
		nx_s9.sat = st_s8.sat || rw.sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_a;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_a;

			// First multiply level: squares of the velocities, and rho*V.
			st_s2  <= st_s1;
			p_x_s2 <= mx_a * mx_a;
			p_y_s2 <= mx_b * mx_b;
			p_z_s2 <= st_s1.a * st_s1.vol;

			st_s3 <= nx_s3;
			x_s3  <= rx.v;
			y_s3  <= ry.v;

			st_s4   <= nx_s4;
			ksum_s4 <= ks.v;

			// Second level: kinetic term, and momenta for the reverse direction.
			st_s5  <= st_s4;
			p_k_s5 <= st_s4.a * ksum_s4;
			p_u_s5 <= st_s4.r0 * st_s4.b;
			p_v_s5 <= st_s4.r0 * st_s4.c;

			st_s6 <= nx_s6;
			ke_s6 <= rk.v;

			st_s7  <= nx_s7;
			sum_s7 <= sm.v;

			// Third level: (gamma-1)*eint, or V*(ke + p/(gamma-1)).
			st_s8  <= st_s7;
			p_w_s8 <= ((st_s7.op == OP_PRIM_TO_CONS) ? st_s7.vol : cfg.gm1) * sum_s7;

			st_s9 <= nx_s9;
			w_s9  <= rw.v;
		end
	end

	evc_div u_div_b (.clk(clk), .en(en), .num(w_s9), .den(st_s9.vol),
		.quo(q4), .zd(zd4), .sat(sat4));

	always_comb begin
		sb_in.op   = st_s9.op;
		sb_in.ni   = st_s9.ni;
		sb_in.last = st_s9.last;
		sb_in.zd   = st_s9.zd;
		sb_in.sat  = st_s9.sat;
		sb_in.r0   = st_s9.r0;
		sb_in.r1   = st_s9.r1;
		sb_in.r2   = st_s9.r2;
		sb_in.w    = w_s9;
	end

	evc_delay u_dly_b (.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s9),
		.dat_in(SIDE_W'(sb_in)), .vld_out(vld_b), .dat_out(dat_b));

	assign sb_out = side_b_t'(dat_b[$bits(side_b_t)-1:0]);

	always_comb begin
		if (sb_out.op == OP_CONS_TO_PRIM) begin
			fin_zd  = sb_out.zd || zd4;
			fin_sat = sb_out.sat || sat4;
			fin_r3  = q4;
		end else begin
			fin_zd  = sb_out.zd;
			fin_sat = sb_out.sat;
			fin_r3  = sb_out.w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (en) begin
			ovld_q <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= sb_out.last;
			if (sb_out.ni) begin
				first_q  <= '0;
				second_q <= '0;
				third_q  <= '0;
				fourth_q <= '0;
				status_q <= ST_NOT_IMPL;
			end else begin
				first_q  <= sb_out.r0;
				second_q <= sb_out.r1;
				third_q  <= sb_out.r2;
				fourth_q <= fin_r3;
				if (fin_zd) begin
					status_q <= ST_ZERO_DIV;
				end else if (fin_sat) begin
					status_q <= ST_SAT;
				end else begin
					status_q <= ST_OK;
				end
			end
		end
	end

	assign results.valid        = ovld_q;
	assign results.out_first    = first_q;
	assign results.out_second   = second_q;
	assign results.out_third    = third_q;
	assign results.out_fourth   = fourth_q;
	assign results.status_code  = status_q;
	assign results.end_of_sweep = last_q;

endmodule

`default_nettype wire

// ===== hdl/euler_variable_converter_core.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter core
// Ideal-gas conversion between conserved and primitive cell variables.
// ----------------------------------------------------------------------------
// Cells arrive on the cells channel, one per transfer; each gives exactly one
// transfer on the results channel, in order. The regs channel writes the
// geometry mode (index 0) and gamma (index 1); it is always ready and must
// only be used while no cell is in flight.
// A cell reaches the results channel through two 49-stage radix-2 dividers
// (one quotient bit per stage) in series, with nine multiply and rounding
// stages and the queue and output registers around them. One cell per cycle
// is sustained while the receiver is ready.
// When the receiver stalls, the whole back end holds its place; the front
// queue keeps taking cells until its two entries are full, then drops
// ready. Reset clears the queue, all valid bits and the registers to 1D
// mode with gamma about 1.4; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_variable_converter_core (
	input  logic         clk,
	input  logic         arst_n,
	evc_cell_if.sink     cells,
	evc_result_if.source results,
	evc_cfg_if.sink      regs
);
	import evc_pkg::*;

	logic [1:0]         mode_q;
	logic [GAMMA_W-1:0] gamma_q;
	cfg_t               cfg;
	logic               item_vld;
	item_t              item;
	logic               pop;

	assign regs.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= GEO_1D;
			gamma_q <= GAMMA_RESET;
		end else if (regs.valid) begin
			case (regs.index)
				REG_GEOMETRY:  mode_q  <= regs.data[1:0];
				REG_ADIABATIC: gamma_q <= regs.data[GAMMA_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.gm1  = word_t'({1'b0, gamma_q}) - Q_ONE;

	evc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cells    (cells),
		.cfg      (cfg),
		.pop      (pop),
		.item_vld (item_vld),
		.item     (item)
	);

	evc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.item_vld (item_vld),
		.item     (item),
		.pop      (pop),
		.results  (results)
	);

endmodule

`default_nettype wire

// ===== hdl/evc_checker.sv =====
// ----------------------------------------------------------------------------
// Euler variable converter checker
// Port-level checks on results and the register channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euler_variable_converter_core_assert.svh"

module evc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             results_valid,
	input logic             results_ready,
	input evc_pkg::word_t   out_first,
	input evc_pkg::word_t   out_second,
	input evc_pkg::word_t   out_third,
	input evc_pkg::word_t   out_fourth,
	input evc_pkg::status_t status_code,
	input logic             regs_valid,
	input logic             regs_ready
);
	import evc_pkg::*;

	// A mode without an implementation must give all-zero values.
	`EVC_ASSERT_SAME(a_not_impl_zero, results_valid && status_code == ST_NOT_IMPL, out_first == '0 && out_second == '0 && out_third == '0 && out_fourth == '0, "not-implemented result carries non-zero values")

	`EVC_ASSERT_NEXT(a_result_hold, results_valid && !results_ready, results_valid && $stable(out_first) && $stable(out_fourth) && $stable(status_code), "stalled result changed")

	`EVC_ASSERT_SAME(a_regs_ready, regs_valid, regs_ready, "register write was held off")

endmodule

bind euler_variable_converter_core evc_checker u_evc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.out_first     (results.out_first),
	.out_second    (results.out_second),
	.out_third     (results.out_third),
	.out_fourth    (results.out_fourth),
	.status_code   (results.status_code),
	.regs_valid    (regs.valid),
	.regs_ready    (regs.ready)
);

`default_nettype wire

// ===== bench/tb_euler_variable_converter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euler variable converter core testbench
// Streams cells in both conversion directions through the converter under
// several geometry and gamma settings, with random gaps and stalls on both
// channels, and checks every result against an independent predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import evc_pkg::*;

	localparam int LATENCY     = 108;
	localparam int CYCLE_LIMIT = 900000;
	localparam longint WMAX    = 64'sd2147483647;
	localparam longint WMIN    = -64'sd2147483648;

	typedef struct {
		logic  op;
		word_t vol, mass, mx, my, energy, dens, vx, vy, pres;
		logic  last;
	} cell_t;

	typedef struct {
		word_t   first, second, third, fourth;
		status_t status;
		logic    eos;
	} conv_t;

	// A directed row: the cell, and an expected result where one is typed in.
	typedef struct {
		cell_t stim;
		logic  typed;
		conv_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	evc_cell_if   cells();
	evc_result_if results();
	evc_cfg_if    regs();

	euler_variable_converter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (cells.sink),
		.results(results.source),
		.regs   (regs.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [1:0]         geo_mode = GEO_1D;
	logic [GAMMA_W-1:0] gamma_q  = GAMMA_RESET;
	conv_t expected_q[$];
	int    mismatches = 0;
	int    checked    = 0;
	int    sent       = 0;
	int    cycles     = 0;

	// Saturation and zero-divisor flags gathered over one cell.
	logic f_zd, f_sat;

	function automatic longint clamp_q(longint v);
		if (v > WMAX) begin f_sat = 1'b1; return WMAX; end
		if (v < WMIN) begin f_sat = 1'b1; return WMIN; end
		return v;
	endfunction

	function automatic longint mul_sh(longint a, longint b, int sh);
		logic [63:0] p, r;
		longint v;
		p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
		r = (p + (64'd1 << (sh - 1))) >> sh;
		v = longint'(r);
		if ((a < 0) != (b < 0)) v = -v;
		return clamp_q(v);
	endfunction

	function automatic longint div_q(longint n, longint d);
		logic [63:0] un, ud, r;
		longint v;
		if (d == 0) begin
			f_zd = 1'b1;
			return n > 0 ? WMAX : (n < 0 ? WMIN : 0);
		end
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		r = ((un << FRAC_BITS) + (ud >> 1)) / ud;
		v = longint'(r);
		if ((n < 0) != (d < 0)) v = -v;
		return clamp_q(v);
	endfunction

	function automatic conv_t convert_cell(cell_t c);
		conv_t o;
		longint r0, r1, r2, r3, gm1, ks, ke, ei, vol, m, rho, u, v;
		logic two_d;
		f_zd = 1'b0;
		f_sat = 1'b0;
		r0 = 0; r1 = 0; r2 = 0; r3 = 0;
		two_d = (geo_mode == GEO_2D);
		o.eos = c.last;
		if (geo_mode > GEO_2D) begin
			o.status = ST_NOT_IMPL;
		end else begin
			vol = c.vol;
			gm1 = clamp_q(longint'(gamma_q) - 65536);
			if (c.op == OP_CONS_TO_PRIM) begin
				m = c.mass;
				r0 = div_q(m, vol);
				r1 = div_q(c.mx, m);
				r2 = two_d ? div_q(c.my, m) : 0;
				ks = clamp_q(mul_sh(r1, r1, FRAC_BITS) + mul_sh(r2, r2, FRAC_BITS));
				ke = mul_sh(m, ks, FRAC_BITS + 1);
				ei = clamp_q(longint'(c.energy) - ke);
				r3 = div_q(mul_sh(gm1, ei, FRAC_BITS), vol);
			end else begin
				rho = c.dens;
				u = c.vx;
				v = two_d ? longint'(c.vy) : 0;
				r0 = mul_sh(rho, vol, FRAC_BITS);
				r1 = mul_sh(r0, u, FRAC_BITS);
				r2 = two_d ? mul_sh(r0, v, FRAC_BITS) : 0;
				ks = clamp_q(mul_sh(u, u, FRAC_BITS) + mul_sh(v, v, FRAC_BITS));
				ke = mul_sh(rho, ks, FRAC_BITS + 1);
				ei = div_q(c.pres, gm1);
				r3 = mul_sh(vol, clamp_q(ke + ei), FRAC_BITS);
			end
			o.status = f_zd ? ST_ZERO_DIV : (f_sat ? ST_SAT : ST_OK);
		end
		o.first = word_t'(r0);
		o.second = word_t'(r1);
		o.third = word_t'(r2);
		o.fourth = word_t'(r3);
		return o;
	endfunction

	task automatic report(string what, conv_t got, conv_t exp);
		mismatches++;
		$display("mismatch %0s cycle %0d: got %h %h %h %h %0d %0b exp %h %h %h %h %0d %0b",
			what, cycles, got.first, got.second, got.third, got.fourth, got.status, got.eos,
			exp.first, exp.second, exp.third, exp.fourth, exp.status, exp.eos);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 32'h0004_0000));
			2: return -word_t'($urandom_range(0, 32'h0004_0000));
			3: return word_t'($urandom_range(0, 32'h0000_1000));
			4: return word_t'($urandom_range(32'h0000_8000, 32'h0002_0000));
			default: return word_t'(0);
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		c.op = 1'($urandom_range(0, 1));
		c.vol = rand_word(); c.mass = rand_word(); c.mx = rand_word();
		c.my = rand_word(); c.energy = rand_word(); c.dens = rand_word();
		c.vx = rand_word(); c.vy = rand_word(); c.pres = rand_word();
		c.last = ($urandom_range(0, 15) == 0);
		// Mostly physical cells: positive volume, mass and density.
		if ($urandom_range(0, 3) != 0) begin
			c.vol = word_t'($urandom_range(32'h0000_4000, 32'h0004_0000));
			c.mass = word_t'($urandom_range(32'h0000_4000, 32'h0004_0000));
			c.dens = word_t'($urandom_range(32'h0000_4000, 32'h0004_0000));
			c.pres = word_t'($urandom_range(32'h0000_1000, 32'h0004_0000));
		end
		return c;
	endfunction

	function automatic cell_t mk(logic op, word_t vol, word_t m, word_t mx, word_t my,
		word_t e, word_t d, word_t vx, word_t vy, word_t p, logic last);
		cell_t c;
		c.op = op; c.vol = vol; c.mass = m; c.mx = mx; c.my = my; c.energy = e;
		c.dens = d; c.vx = vx; c.vy = vy; c.pres = p; c.last = last;
		return c;
	endfunction

	// Drives the whole cell on the falling edge and holds it until taken.
	// Valid stays high after a transfer so that cells can follow back to back;
	// a gap, a drain or a hold-off drops it.
	task automatic send_cell(cell_t c);
		int g;
		g = gap_len();
		if (g > 0) begin
			cells.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		cells.valid <= 1'b1;
		cells.operation <= c.op;
		cells.cell_volume <= c.vol;
		cells.cell_mass <= c.mass;
		cells.cell_momentum_x <= c.mx;
		cells.cell_momentum_y <= c.my;
		cells.cell_energy <= c.energy;
		cells.cell_density <= c.dens;
		cells.cell_velocity_x <= c.vx;
		cells.cell_velocity_y <= c.vy;
		cells.cell_pressure <= c.pres;
		cells.last_cell <= c.last;
		do @(posedge clk); while (!cells.ready);
		expected_q.push_back(convert_cell(c));
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		cells.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [GAMMA_W-1:0] val);
		regs.valid <= 1'b1;
		regs.index <= idx;
		regs.data <= val;
		do @(posedge clk); while (!regs.ready);
		if (idx == REG_GEOMETRY) geo_mode = val[1:0];
		else gamma_q = val;
		@(negedge clk);
		regs.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: random stalls, checking at each accepted transfer.
	initial begin
		int s;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (s > 0) begin
				s--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
				if ($urandom_range(0, 9) == 0) s = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		conv_t got, exp;
		cycles <= cycles + 1;
		if (arst_n && results.valid && results.ready) begin
			got.first = results.out_first;
			got.second = results.out_second;
			got.third = results.out_third;
			got.fourth = results.out_fourth;
			got.status = results.status_code;
			got.eos = results.end_of_sweep;
			if (expected_q.size() == 0) begin
				report("unexpected result", got, got);
			end else begin
				exp = expected_q.pop_front();
				checked++;
				if (got.first !== exp.first) report("out_first", got, exp);
				else if (got.second !== exp.second) report("out_second", got, exp);
				else if (got.third !== exp.third) report("out_third", got, exp);
				else if (got.fourth !== exp.fourth) report("out_fourth", got, exp);
				else if (got.status !== exp.status) report("status_code", got, exp);
				else if (got.eos !== exp.eos) report("end_of_sweep", got, exp);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_q.size());
			$display("euler_variable_converter_core regression: fail");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		logic [GAMMA_W-1:0] gammas[4];
		cells.valid = 1'b0;
		cells.operation = OP_CONS_TO_PRIM;
		cells.cell_volume = '0; cells.cell_mass = '0; cells.cell_momentum_x = '0;
		cells.cell_momentum_y = '0; cells.cell_energy = '0; cells.cell_density = '0;
		cells.cell_velocity_x = '0; cells.cell_velocity_y = '0; cells.cell_pressure = '0;
		cells.last_cell = 1'b0;
		regs.valid = 1'b0;
		regs.index = REG_GEOMETRY;
		regs.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, first at the reset settings (1D, gamma about 1.4).
		rw.typed = 1'b1;
		rw.stim = mk(OP_CONS_TO_PRIM, 0, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		rw.res = '{MAX_WORD, 0, 0, 0, ST_ZERO_DIV, 1'b1};
		rows.push_back(rw);
		rw.stim = mk(OP_CONS_TO_PRIM, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		rw.res = '{MIN_WORD, 0, 0, 0, ST_ZERO_DIV, 1'b0};
		rows.push_back(rw);
		// Zero mass makes the velocity divisor zero.
		rw.stim = mk(OP_CONS_TO_PRIM, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		rw.res = '{0, 0, 0, 0, ST_ZERO_DIV, 1'b0};
		rows.push_back(rw);
		rw.stim = mk(OP_PRIM_TO_CONS, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 1'b1);
		rw.res = '{32'h10000, 0, 0, 0, ST_OK, 1'b1};
		rows.push_back(rw);
		rw.typed = 1'b0;
		rw.stim = mk(OP_PRIM_TO_CONS, 32'h7FFF_FFFF, 0, 0, 0, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		rows.push_back(rw);
		rw.stim = mk(OP_CONS_TO_PRIM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1'b1);
		rows.push_back(rw);
		rw.stim = mk(OP_CONS_TO_PRIM, 32'h20000, 32'h20000, 32'h30000, 32'h10000,
			32'h80000, 0, 0, 0, 0, 1'b0);
		rows.push_back(rw);
		rw.stim = mk(OP_PRIM_TO_CONS, 32'h20000, 0, 0, 0, 0, 32'h18000, 32'hFFFF_0000,
			32'h8000, 32'h28000, 1'b0);
		rows.push_back(rw);
		rw.stim = mk(OP_CONS_TO_PRIM, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 1'b1);
		rows.push_back(rw);
		foreach (rows[i]) begin
			send_cell(rows[i].stim);
			if (rows[i].typed) expected_q[expected_q.size()-1] = rows[i].res;
		end
		drain();

		// Extreme settings: 2D with the untyped rows, gamma of one, and the unimplemented modes.
		write_reg(REG_GEOMETRY, GEO_2D);
		foreach (rows[i]) if (!rows[i].typed) send_cell(rows[i].stim);
		drain();
		write_reg(REG_ADIABATIC, 31'd65536);
		send_cell(mk(OP_PRIM_TO_CONS, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0,
			32'h10000, 1'b0));
		drain();
		write_reg(REG_GEOMETRY, 2'd2);
		send_cell(rows[4].stim);
		expected_q[expected_q.size()-1] = '{0, 0, 0, 0, ST_NOT_IMPL, 1'b0};
		drain();
		write_reg(REG_GEOMETRY, 2'd3);
		send_cell(rows[5].stim);
		expected_q[expected_q.size()-1] = '{0, 0, 0, 0, ST_NOT_IMPL, 1'b1};
		drain();

		// Random phases over several geometry and gamma settings.
		gammas = '{31'd91750, 31'd65537, 31'h7FFF_FFFF, 31'd109227};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_GEOMETRY, ph % 4 == 3 ? 2'($urandom_range(2, 3)) : 2'(ph % 2));
			write_reg(REG_ADIABATIC, ph == 7 ? 31'($urandom) : gammas[ph % 4]);
			for (int k = 0; k < 115; k++) begin
				// Hold off once until everything sent has come back.
				if (ph == 2 && k == 50) begin
					cells.valid <= 1'b0;
					do @(negedge clk); while (expected_q.size() != 0);
				end
				send_cell(rand_cell());
			end
			drain();
		end

		$display("sent %0d cells, checked %0d results over both directions,", sent, checked);
		$display("1D, 2D and unimplemented modes, gamma from one to its maximum");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("euler_variable_converter_core regression: pass");
		end else begin
			$display("euler_variable_converter_core regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
